[rtl/mts_pkg.sv]
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the min tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int DATA_W = 32;
    localparam int SIZE_W = 5;

    typedef logic [1:0]               t_op;
    typedef logic [1:0]               t_status;
    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [SIZE_W-1:0]        t_size;

    localparam t_op OP_PUSH  = 2'd0;
    localparam t_op OP_POP   = 2'd1;
    localparam t_op OP_QUERY = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        t_status status;
        t_data   popped_value;
        t_data   current_min;
        t_size   stack_size;
    } t_res;

endpackage

[rtl/mts_if.sv]
// ----------------------------------------------------------------------------
// mts_if
// Command and response channels of the min tracking stack.
// ----------------------------------------------------------------------------
interface mts_in_if
    import mts_pkg::*;
();
    logic  valid;
    logic  ready;
    t_op   opcode;
    t_data value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface mts_out_if
    import mts_pkg::*;
();
    logic    valid;
    logic    ready;
    t_status status;
    t_data   popped_value;
    t_data   current_min;
    t_size   stack_size;

    modport source (output valid, output status, output popped_value,
                    output current_min, output stack_size, input ready);
    modport sink   (input valid, input status, input popped_value,
                    input current_min, input stack_size, output ready);
endinterface

[rtl/mts_ram.sv]
// ----------------------------------------------------------------------------
// mts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mts_outq.sv]
// ----------------------------------------------------------------------------
// mts_outq
// Two-beat response queue: output register plus skid stage.
// ----------------------------------------------------------------------------
module mts_outq
    import mts_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_res          i_res,
    output logic          o_space,
    mts_out_if.source     o_rsp
);

    t_res       r_q0, n_q0;
    t_res       r_q1, n_q1;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;

    assign pop     = o_rsp.valid && o_rsp.ready;
    assign o_space = (r_cnt != 2'd2);

    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = r_cnt;
        case ({i_push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    n_q0 = i_res;
                end else begin
                    n_q1 = i_res;
                end
                n_cnt = r_cnt + 2'd1;
            end
            2'b01: begin
                n_q0  = r_q1;
                n_cnt = r_cnt - 2'd1;
            end
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    n_q0 = i_res;
                end else begin
                    n_q0 = r_q1;
                    n_q1 = i_res;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_rsp.valid        = (r_cnt != 2'd0);
    assign o_rsp.status       = r_q0.status;
    assign o_rsp.popped_value = r_q0.popped_value;
    assign o_rsp.current_min  = r_q0.current_min;
    assign o_rsp.stack_size   = r_q0.stack_size;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_push)
        else $error("response pushed into full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("response queue count out of range");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |=> (r_cnt != 2'd2))
        else $error("response queue grew by two beats");

endmodule

[rtl/mts_ctrl.sv]
// ----------------------------------------------------------------------------
// mts_ctrl
// Stack engine: counters, cached tops, memory access and refill after a pop.
// ----------------------------------------------------------------------------
module mts_ctrl
    import mts_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_in_if.sink    i_cmd,
    input  logic      i_space,
    output logic      o_res_valid,
    output t_res      o_res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FILL = 2'b10
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_main_cnt, n_main_cnt;
    logic [CW-1:0] r_min_cnt, n_min_cnt;
    t_data         r_main_top, n_main_top;
    t_data         r_min_top, n_min_top;
    t_data         r_popped, n_popped;
    logic          r_min_popped, n_min_popped;

    logic          acc;
    logic          main_we;
    logic          min_we;
    logic [CW-1:0] main_m2;
    logic [CW-1:0] min_m2;
    t_data         main_rdata;
    t_data         min_rdata;
    t_data         min_top_c;

    assign acc       = i_cmd.valid && i_cmd.ready;
    assign min_top_c = (r_min_cnt == '0) ? '0 : r_min_top;
    assign main_m2   = r_main_cnt - CW'(2);
    assign min_m2    = r_min_cnt - CW'(2);

    mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_we),
        .i_waddr (r_main_cnt[AW-1:0]),
        .i_wdata (i_cmd.value),
        .i_raddr (main_m2[AW-1:0]),
        .o_rdata (main_rdata)
    );

    mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (min_we),
        .i_waddr (r_min_cnt[AW-1:0]),
        .i_wdata (i_cmd.value),
        .i_raddr (min_m2[AW-1:0]),
        .o_rdata (min_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_main_cnt   = r_main_cnt;
        n_min_cnt    = r_min_cnt;
        n_main_top   = r_main_top;
        n_min_top    = r_min_top;
        n_popped     = r_popped;
        n_min_popped = r_min_popped;
        main_we      = 1'b0;
        min_we       = 1'b0;
        o_res_valid  = 1'b0;
        o_res.status       = ST_OK;
        o_res.popped_value = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_res_valid = 1'b1;
                    case (i_cmd.opcode)
                        OP_PUSH: begin
                            if (r_main_cnt < CW'(DEPTH)) begin
                                main_we    = 1'b1;
                                n_main_cnt = r_main_cnt + CW'(1);
                                n_main_top = i_cmd.value;
                                if ((r_main_cnt == '0 || i_cmd.value <= min_top_c)
                                        && r_min_cnt < CW'(DEPTH)) begin
                                    min_we    = 1'b1;
                                    n_min_cnt = r_min_cnt + CW'(1);
                                    n_min_top = i_cmd.value;
                                end
                            end else begin
                                o_res.status = ST_FULL;
                            end
                        end
                        OP_POP: begin
                            if (r_main_cnt != '0) begin
                                o_res_valid  = 1'b0;
                                n_state      = S_FILL;
                                n_main_cnt   = r_main_cnt - CW'(1);
                                n_popped     = r_main_top;
                                n_min_popped = (r_min_cnt != '0)
                                               && (r_main_top == r_min_top);
                                if (n_min_popped) begin
                                    n_min_cnt = r_min_cnt - CW'(1);
                                end
                            end else begin
                                o_res.status = ST_EMPTY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_res_valid        = 1'b1;
                o_res.popped_value = r_popped;
                n_state            = S_IDLE;
                n_min_popped       = 1'b0;
                n_main_top         = main_rdata;
                if (r_min_popped) begin
                    n_min_top = min_rdata;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        o_res.current_min = (n_main_cnt == '0 || n_min_cnt == '0) ? '0 : n_min_top;
        o_res.stack_size  = t_size'(n_main_cnt);
    end

    assign i_cmd.ready = (r_state == S_IDLE) && i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_main_cnt   <= '0;
            r_min_cnt    <= '0;
            r_min_popped <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_main_cnt   <= n_main_cnt;
            r_min_cnt    <= n_min_cnt;
            r_min_popped <= n_min_popped;
        end
        r_main_top <= n_main_top;
        r_min_top  <= n_min_top;
        r_popped   <= n_popped;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_cnt <= CW'(DEPTH))
        else $error("stack count above depth");

    a_min_le_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min_cnt <= r_main_cnt)
        else $error("minimum stack deeper than main stack");

    a_fill_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> $past(acc && i_cmd.opcode == OP_POP))
        else $error("refill without a pop");

    a_fill_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |=> (r_state == S_IDLE))
        else $error("refill lasted more than one cycle");

endmodule

[rtl/min_tracking_stack.sv]
// ----------------------------------------------------------------------------
// min_tracking_stack
// Bounded stack of signed 32-bit values that reports its current minimum.
// ----------------------------------------------------------------------------
// Push, query, a push to a full stack and a pop from an empty stack skip
// refill, so they are accepted back to back while the response queue has
// space. A pop that removes an entry enters refill: the new main and minimum
// tops come from the registered read port of both stack memories in the cycle
// after the pop is accepted. A two-beat response queue lets commands keep
// flowing while one response waits. No clearing pass runs after reset.
module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mts_in_if.sink    i_cmd,
    mts_out_if.source o_rsp
);

    logic res_valid;
    t_res res;
    logic space;

    mts_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .i_space     (space),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mts_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_space (space),
        .o_rsp   (o_rsp)
    );

endmodule
